FILE: sv/pcm_pkg.sv
// Shared constants, types and a helper function for the pitch class CV mapper.
package pcm_pkg;

    localparam int NOTES            = 12;
    localparam int PULSE_COUNT_BITS = 16;
    localparam int CV_W             = 16;
    localparam int NOTE_W           = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int IN_DATA_W        = 32;
    localparam int OUT_DATA_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TRIG_ON_NOTE_CHANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_CV_LOW         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_CV_MID         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_CV_HIGH        = 3'd4;

    localparam logic [15:0] PULSE_TICKS_RESET = 16'd48;

    localparam logic signed [CV_W-1:0] CV_MIN       = -16'sd10240;
    localparam logic signed [CV_W-1:0] CV_MAX       = 16'sd20480;
    localparam logic signed [CV_W-1:0] CV_WRAP      = 16'sd20480;
    localparam logic signed [CV_W-1:0] SCHMITT_LOW  = 16'sd20;
    localparam logic signed [CV_W-1:0] SCHMITT_HIGH = 16'sd4096;
    localparam logic [2:0]             SETTLE_LIMIT = 3'd5;

    typedef struct packed {
        logic                            trig_on_note_change;
        logic [15:0]                     pulse_ticks;
        logic [NOTES-1:0][CV_W-1:0]      note_cv;
    } t_cfg;

    typedef struct packed {
        logic                     cv_present;
        logic signed [CV_W-1:0]   cv_in;
        logic signed [CV_W-1:0]   trigger_in;
    } t_item;

    typedef struct packed {
        logic signed [CV_W-1:0]   cv_out;
        logic [NOTES-1:0]         pulse_mask;
        logic [NOTE_W-1:0]        lit_note;
    } t_result;

    // Quantize a pitch CV to note 1..12 from its fractional volt.
    function automatic logic [NOTE_W-1:0] note_of(input logic signed [CV_W-1:0] v);
        logic signed [CV_W-1:0] c;
        logic [14:0]            prod;
        c = v;
        if (c < CV_MIN) c = CV_MIN;
        if (c > CV_MAX) c = CV_MAX;
        if (c < 0) c = c + CV_WRAP;
        prod = 15'(c[10:0]) * 15'(NOTES);
        note_of = prod[14:11] + 4'd1;
    endfunction

endpackage

FILE: sv/pcm_core.sv
// Note quantizer, trigger/settle control and per-note pulse counters.
module pcm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  pcm_pkg::t_item i_item,
    input  pcm_pkg::t_cfg  i_cfg,
    output pcm_pkg::t_result o_result
);
    import pcm_pkg::*;

    localparam int LEN_W = (PULSE_COUNT_BITS > 16) ? PULSE_COUNT_BITS : 16;

    logic                        r_schmitt_high, n_schmitt_high;
    logic                        r_armed, n_armed;
    logic [2:0]                  r_settle_count, n_settle_count;
    logic                        r_settling, n_settling;
    logic [NOTE_W-1:0]           r_last_note, n_last_note;
    logic [PULSE_COUNT_BITS-1:0] r_pulse_left [NOTES];
    logic [PULSE_COUNT_BITS-1:0] n_pulse_left [NOTES];

    logic [NOTE_W-1:0]           note;
    logic [NOTE_W-1:0]           idx;
    logic                        fired;
    logic                        start;
    logic [2:0]                  cnt_inc;
    logic signed [CV_W-1:0]      cv_sel;
    logic [LEN_W-1:0]            len_wide;
    logic [LEN_W-1:0]            len_max;
    logic [PULSE_COUNT_BITS-1:0] len;
    logic [PULSE_COUNT_BITS-1:0] base;
    logic [NOTES-1:0]            mask;

    always_comb begin
        len_wide = LEN_W'(i_cfg.pulse_ticks);
        len_max  = LEN_W'({PULSE_COUNT_BITS{1'b1}});
        len      = PULSE_COUNT_BITS'((len_wide > len_max) ? len_max : len_wide);
    end

    always_comb begin
        note           = note_of(i_item.cv_in);
        idx            = note - 4'd1;
        fired          = 1'b0;
        start          = 1'b0;
        cnt_inc        = 3'd0;
        n_schmitt_high = r_schmitt_high;
        n_armed        = r_armed;
        n_settle_count = r_settle_count;
        n_settling     = r_settling;
        n_last_note    = r_last_note;
        cv_sel         = '0;

        for (int k = 0; k < NOTES; k++) begin
            if (idx == NOTE_W'(k)) cv_sel = i_cfg.note_cv[k];
        end

        if (i_item.cv_present) begin
            if (note != r_last_note && i_cfg.trig_on_note_change) n_armed = 1'b1;
            n_last_note = note;

            if (r_schmitt_high) begin
                if (i_item.trigger_in <= SCHMITT_LOW) n_schmitt_high = 1'b0;
            end else if (i_item.trigger_in >= SCHMITT_HIGH) begin
                n_schmitt_high = 1'b1;
                fired          = 1'b1;
            end

            if (fired) begin
                n_armed        = 1'b1;
                n_settle_count = 3'd0;
                n_settling     = 1'b1;
            end

            if (n_armed) begin
                if (n_settling) begin
                    cnt_inc        = n_settle_count + 3'd1;
                    n_settle_count = cnt_inc;
                    if (cnt_inc > SETTLE_LIMIT) n_settling = 1'b0;
                end else begin
                    start   = 1'b1;
                    n_armed = 1'b0;
                end
            end
        end

        mask = '0;
        for (int k = 0; k < NOTES; k++) begin
            base = r_pulse_left[k];
            if (start && idx == NOTE_W'(k) && len > r_pulse_left[k]) base = len;
            if (base != '0) begin
                mask[k]         = 1'b1;
                n_pulse_left[k] = base - PULSE_COUNT_BITS'(1);
            end else begin
                n_pulse_left[k] = base;
            end
        end

        o_result.cv_out     = i_item.cv_present ? cv_sel : '0;
        o_result.pulse_mask = mask;
        o_result.lit_note   = i_item.cv_present ? note : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_schmitt_high <= 1'b1;
            r_armed        <= 1'b0;
            r_settle_count <= 3'd0;
            r_settling     <= 1'b1;
            r_last_note    <= '0;
            for (int k = 0; k < NOTES; k++) r_pulse_left[k] <= '0;
        end else if (i_step) begin
            r_schmitt_high <= n_schmitt_high;
            r_armed        <= n_armed;
            r_settle_count <= n_settle_count;
            r_settling     <= n_settling;
            r_last_note    <= n_last_note;
            for (int k = 0; k < NOTES; k++) r_pulse_left[k] <= n_pulse_left[k];
        end
    end

endmodule

FILE: sv/pitch_class_cv_mapper_unit.sv
// Top level of the pitch class CV mapper: stream ports, configuration registers, pipeline.
//
// One sample enters per clock cycle: the sample is held in an input register, and
// the note, trigger, settle and pulse logic runs combinationally from there into
// the result register. Sustained rate is one sample per cycle,
// limited only by the output side's tready. The configuration port is always ready;
// register 0 arms on note change, 1 sets pulse length, 2..4 hold the twelve note CVs.
module pitch_class_cv_mapper_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [pcm_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // cv_in, trigger_in
    input  logic                             i_s_axis_tuser,  // cv_present
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [pcm_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // cv_out, pulse_mask, lit_note
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pcm_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result result;
    logic    advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_result.lit_note, r_result.pulse_mask, r_result.cv_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_on_note_change <= 1'b0;
            r_cfg.pulse_ticks         <= PULSE_TICKS_RESET;
            r_cfg.note_cv             <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TRIG_ON_NOTE_CHANGE: r_cfg.trig_on_note_change <= i_cfg_data[0];
                REG_PULSE_TICKS:         r_cfg.pulse_ticks         <= i_cfg_data[15:0];
                REG_NOTE_CV_LOW:         r_cfg.note_cv[3:0]        <= i_cfg_data;
                REG_NOTE_CV_MID:         r_cfg.note_cv[7:4]        <= i_cfg_data;
                REG_NOTE_CV_HIGH:        r_cfg.note_cv[11:8]       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item.cv_present <= i_s_axis_tuser;
            r_item.cv_in      <= i_s_axis_tdata[15:0];
            r_item.trigger_in <= i_s_axis_tdata[31:16];
        end
    end

    pcm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_result <= result;
    end

endmodule

FILE: tb/pitch_class_cv_mapper_unit_tb.sv
// Self-checking testbench for the pitch class CV mapper: directed rows, then randomized phases.
module pitch_class_cv_mapper_unit_tb;
    import pcm_pkg::*;

    localparam int CLAMP_LO       = -10240;
    localparam int CLAMP_HI       = 20480;
    localparam int WRAP_ADD       = 20480;
    localparam int TRIG_OFF_LEVEL = 20;
    localparam int TRIG_ON_LEVEL  = 4096;
    localparam int SETTLE_TICKS   = 5;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 220;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        bit                 present;
        logic signed [15:0] cv;
        logic signed [15:0] trig;
        bit                 known;
        t_result            want;
    } t_probe_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    logic                    i_s_axis_tuser = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // mapper state as seen by the predictor
    bit                 arm_on_change = 1'b0;
    logic [15:0]        pulse_len = 16'd48;
    logic signed [15:0] note_cv [NOTES] = '{default: '0};
    bit                 schmitt_hi = 1'b1;
    bit                 armed = 1'b0;
    logic [2:0]         settle_cnt = 3'd0;
    bit                 settling = 1'b1;
    logic [3:0]         last_note = 4'd0;
    logic [15:0]        pulse_left [NOTES] = '{default: '0};

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      idle_en = 1'b1;

    logic [15:0] cv_extremes [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hD800, 16'h5000};

    t_probe_row probe_rows [23] = '{
        '{1'b1, 16'sd0,      16'sd0,      1'b1, '{16'sd0, 12'h000, 4'd1}},
        '{1'b0, 16'sd0,      16'sd0,      1'b1, '{16'sd0, 12'h000, 4'd0}},
        '{1'b1, -16'sd32768, 16'sd0,      1'b0, '0},
        '{1'b1, 16'sd32767,  16'sd0,      1'b0, '0},
        '{1'b1, -16'sd10240, 16'sd0,      1'b0, '0},
        '{1'b1, 16'sd20480,  16'sd0,      1'b0, '0},
        '{1'b1, -16'sd10241, 16'sd0,      1'b0, '0},
        '{1'b1, 16'sd20481,  16'sd0,      1'b0, '0},
        '{1'b1, -16'sd1,     16'sd0,      1'b0, '0},
        '{1'b1, 16'sd2047,   16'sd0,      1'b0, '0},
        '{1'b1, 16'sd171,    16'sd4095,   1'b0, '0},
        '{1'b1, 16'sd171,    16'sd4096,   1'b0, '0},
        '{1'b0, 16'sd171,    16'sd32767,  1'b0, '0},
        '{1'b1, 16'sd171,    -16'sd32768, 1'b0, '0},
        '{1'b1, 16'sd171,    16'sd4096,   1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b1, 16'sd171,    16'sd21,     1'b0, '0},
        '{1'b0, 16'sd0,      16'sd0,      1'b0, '0},
        '{1'b1, -16'sd32768, 16'sd20,     1'b0, '0}
    };

    pitch_class_cv_mapper_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance the mapper by one sample and return the result it produces.
    function automatic t_result advance_mapper(input t_item it);
        t_result    r;
        int         v;
        logic [3:0] n;
        logic [3:0] idx;
        bit         fired;
        r = '0;
        fired = 1'b0;
        if (it.cv_present) begin
            v = it.cv_in;
            if (v < CLAMP_LO) v = CLAMP_LO;
            if (v > CLAMP_HI) v = CLAMP_HI;
            if (v < 0) v = v + WRAP_ADD;
            n = 4'(((v & 2047) * 12) >> 11) + 4'd1;
            if (n != last_note) begin
                if (arm_on_change) armed = 1'b1;
                last_note = n;
            end
            idx = last_note - 4'd1;
            r.cv_out = note_cv[idx];
            if (schmitt_hi) begin
                if (it.trigger_in <= TRIG_OFF_LEVEL) schmitt_hi = 1'b0;
            end else if (it.trigger_in >= TRIG_ON_LEVEL) begin
                schmitt_hi = 1'b1;
                fired = 1'b1;
            end
            if (fired) begin
                armed = 1'b1;
                settle_cnt = 3'd0;
                settling = 1'b1;
            end
            if (armed) begin
                if (settling) begin
                    settle_cnt = settle_cnt + 3'd1;
                    if (settle_cnt > SETTLE_TICKS) settling = 1'b0;
                end else begin
                    if (pulse_len > pulse_left[idx]) pulse_left[idx] = pulse_len;
                    armed = 1'b0;
                end
            end
            r.lit_note = last_note;
        end
        for (int i = 0; i < NOTES; i++) begin
            if (pulse_left[i] != 0) begin
                pulse_left[i] = pulse_left[i] - 16'd1;
                r.pulse_mask[i] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_sample(input t_item it, input bit known, input t_result want);
        t_result predicted;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.trigger_in, it.cv_in};
        i_s_axis_tuser  <= it.cv_present;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = advance_mapper(it);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_TRIG_ON_NOTE_CHANGE: arm_on_change = data[0];
            REG_PULSE_TICKS:         pulse_len = data[15:0];
            REG_NOTE_CV_LOW, REG_NOTE_CV_MID, REG_NOTE_CV_HIGH: begin
                for (int k = 0; k < 4; k++)
                    note_cv[(index - REG_NOTE_CV_LOW) * 4 + k] = data[16*k +: 16];
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.cv_out     = o_m_axis_tdata[15:0];
            got.pulse_mask = o_m_axis_tdata[27:16];
            got.lit_note   = o_m_axis_tdata[31:28];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.cv_out !== want.cv_out) begin
                    $display("%0t: cv_out expected %0d, actual %0d", $time, want.cv_out,
                             got.cv_out);
                    mismatch_count++;
                end
                if (got.pulse_mask !== want.pulse_mask) begin
                    $display("%0t: pulse_mask expected %h, actual %h", $time, want.pulse_mask,
                             got.pulse_mask);
                    mismatch_count++;
                end
                if (got.lit_note !== want.lit_note) begin
                    $display("%0t: lit_note expected %0d, actual %0d", $time, want.lit_note,
                             got.lit_note);
                    mismatch_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_item              it;
        logic signed [15:0] cur_cv;
        logic signed [15:0] cur_trig;
        logic [63:0]        junk;
        logic [63:0]        cv_word [3];
        logic [15:0]        len;
        bit                 arm;
        cur_cv = '0;
        cur_trig = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[r]) begin
            it.cv_present = probe_rows[r].present;
            it.cv_in      = probe_rows[r].cv;
            it.trigger_in = probe_rows[r].trig;
            send_sample(it, probe_rows[r].known, probe_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0:       begin arm = 1'b1; len = 16'd1; end
                1:       begin arm = 1'b0; len = PULSE_TICKS_RESET; end
                2:       begin arm = 1'b1; len = 16'hFFFF; end
                3:       begin arm = 1'b1; len = 16'd0; end
                4:       begin arm = 1'b0; len = 16'($urandom_range(1, 300)); end
                5:       begin arm = 1'b1; len = 16'($urandom_range(1, 20)); end
                default: begin arm = 1'b1; len = 16'($urandom_range(2, 40)); end
            endcase
            for (int w = 0; w < 3; w++) begin
                for (int k = 0; k < 4; k++) begin
                    if (p == 1)
                        cv_word[w][16*k +: 16] = cv_extremes[$urandom_range(0, 5)];
                    else if (p % 2 == 0)
                        cv_word[w][16*k +: 16] = 16'($urandom);
                    else
                        cv_word[w][16*k +: 16] = 16'(int'($urandom_range(0, 30720)) - 10240);
                end
            end
            junk = {$urandom, $urandom};
            write_reg(REG_TRIG_ON_NOTE_CHANGE, {junk[63:1], arm});
            junk = {$urandom, $urandom};
            write_reg(REG_PULSE_TICKS, {junk[63:16], len});
            write_reg(REG_NOTE_CV_LOW, cv_word[0]);
            write_reg(REG_NOTE_CV_MID, cv_word[1]);
            write_reg(REG_NOTE_CV_HIGH, cv_word[2]);
            i_cfg_valid <= 1'b0;
            idle_en = (p != PHASES - 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: cur_cv = 16'($urandom);
                        1: cur_cv = 16'(int'($urandom_range(0, 30720)) - 10240);
                        2: cur_cv = 16'(int'($urandom_range(0, 14)) * 2048 - 10240
                                        + int'($urandom_range(0, 11)) * 171
                                        + int'($urandom_range(0, 170)));
                        default: cur_cv = cv_extremes[$urandom_range(0, 5)];
                    endcase
                end
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 3))
                        0: cur_trig = 16'(int'($urandom_range(0, 32788)) - 32768);
                        1: cur_trig = 16'($urandom_range(4096, 32767));
                        2: cur_trig = 16'($urandom_range(21, 4095));
                        default: cur_trig = 16'($urandom);
                    endcase
                end
                it.cv_present = ($urandom_range(0, 15) != 0);
                it.cv_in      = cur_cv;
                it.trigger_in = cur_trig;
                send_sample(it, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
